@@ rtl/core/i2a_pkg.sv @@
package i2a_pkg;

    localparam int CHAR_W   = 7;
    localparam int CFG_W    = 8;
    localparam int DD_STEPS = 8;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [CFG_W-1:0]  t_cfg;

    localparam t_cfg  CFG_RESET  = 8'd12;
    localparam t_char CHAR_ZERO  = 7'd48;
    localparam t_char CHAR_MINUS = 7'd45;

    function automatic logic [3:0] dd_adjust(input logic [3:0] digit);
        dd_adjust = (digit >= 4'd5) ? digit + 4'd3 : digit;
    endfunction

endpackage

@@ rtl/core/int32_to_decimal_ascii.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_value
// result    out        o_out_valid / i_out_ready  o_char_code, o_is_last, o_error
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_buffer_size
//
// Binary to BCD runs in ceil(VALUE_WIDTH/8) double-dabble stages, up to eight shifts each,
// behind a magnitude stage and ahead of a digit count stage.
// The character emitter sends one character per cycle while the output is not stalled.
// An item gives digits + sign characters, at most MAX_DIGITS+1 (11 by default), or a single
// character on error; the emitter takes the next item only after an item's last character.
// Reset clears all valid bits and sets the buffer size to 12; the config port is always ready.
// A stalled result holds its register; upstream stages hold until space opens.
module int32_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [i2a_pkg::CHAR_W-1:0]    o_char_code,
    output logic                          o_is_last,
    output logic                          o_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [i2a_pkg::CFG_W-1:0]     i_cfg_buffer_size
);
    import i2a_pkg::*;

    localparam int FULL_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int DD_DIGITS   = (FULL_DIGITS > MAX_DIGITS) ? FULL_DIGITS : MAX_DIGITS;
    localparam int BCD_W       = 4 * DD_DIGITS;
    localparam int NUM_DD      = (VALUE_WIDTH + DD_STEPS - 1) / DD_STEPS;
    localparam int LAST        = NUM_DD + 1;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int TOT_W       = $clog2(MAX_DIGITS + 2);
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int HI_W        = $clog2(DD_DIGITS + 1);

    t_cfg                   r_buffer_size;

    logic [LAST:0]          r_v;
    logic [LAST:0]          acc;
    logic [BCD_W-1:0]       r_bcd [0:NUM_DD];
    logic [VALUE_WIDTH-1:0] r_bin [0:NUM_DD];
    logic                   r_neg [0:NUM_DD];
    logic                   r_err [0:NUM_DD];
    logic [BCD_W-1:0]       n_bcd [1:NUM_DD];
    logic [VALUE_WIDTH-1:0] n_bin [1:NUM_DD];

    logic [3:0]             r_cdig [0:MAX_DIGITS-1];
    logic [CNT_W-1:0]       r_ccnt;
    logic                   r_cneg;
    logic                   r_cerr;
    logic [CNT_W-1:0]       n_ccnt;

    logic                   r_em_valid;
    logic [3:0]             r_em_dig [0:MAX_DIGITS-1];
    logic [CNT_W-1:0]       r_em_cnt;
    logic                   r_em_neg;
    logic                   r_em_err;
    logic [TOT_W-1:0]       r_em_pos;

    logic                   r_out_valid;
    t_char                  r_char;
    logic                   r_last;
    logic                   r_error;

    logic [VALUE_WIDTH-1:0] in_mag;
    logic [TOT_W-1:0]       em_total;
    logic [TOT_W-1:0]       em_idx;
    logic [3:0]             em_digit;
    logic                   em_last;
    t_char                  em_char;
    logic                   out_load;
    logic                   em_can;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = acc[0];
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;
    assign o_error     = r_error;

    assign in_mag = i_value[VALUE_WIDTH-1] ? (~i_value + VALUE_WIDTH'(1)) : i_value;

    always_comb begin
        logic [BCD_W-1:0]       bcd;
        logic [VALUE_WIDTH-1:0] bin;
        for (int k = 1; k <= NUM_DD; k++) begin
            bcd = r_bcd[k-1];
            bin = r_bin[k-1];
            for (int j = 0; j < DD_STEPS; j++) begin
                if ((k - 1) * DD_STEPS + j < VALUE_WIDTH) begin
                    for (int d = 0; d < DD_DIGITS; d++) begin
                        bcd[d*4 +: 4] = dd_adjust(bcd[d*4 +: 4]);
                    end
                    bcd = {bcd[BCD_W-2:0], bin[VALUE_WIDTH-1]};
                    bin = {bin[VALUE_WIDTH-2:0], 1'b0};
                end
            end
            n_bcd[k] = bcd;
            n_bin[k] = bin;
        end
    end

    always_comb begin
        logic [HI_W-1:0] hi;
        hi = '0;
        for (int d = 0; d < DD_DIGITS; d++) begin
            if (r_bcd[NUM_DD][d*4 +: 4] != 4'd0) begin
                hi = HI_W'(d + 1);
            end
        end
        if (hi == '0) begin
            hi = HI_W'(1);
        end
        n_ccnt = (int'(hi) > MAX_DIGITS) ? CNT_W'(MAX_DIGITS) : CNT_W'(hi);
    end

    always_comb begin
        em_total = TOT_W'(r_em_cnt) + TOT_W'(r_em_neg);
        em_idx   = em_total - TOT_W'(1) - r_em_pos;
        em_digit = r_em_dig[em_idx[IDX_W-1:0]];
        em_last  = r_em_err || (r_em_pos == em_total - TOT_W'(1));
        if (r_em_err) begin
            em_char = '0;
        end else if (r_em_neg && r_em_pos == '0) begin
            em_char = CHAR_MINUS;
        end else begin
            em_char = CHAR_ZERO + t_char'(em_digit);
        end
    end

    assign out_load = !r_out_valid || i_out_ready;
    assign em_can   = !r_em_valid || (out_load && em_last);

    always_comb begin
        acc[LAST] = !r_v[LAST] || em_can;
        for (int k = LAST - 1; k >= 0; k--) begin
            acc[k] = !r_v[k] || acc[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= CFG_RESET;
            r_v           <= '0;
            r_em_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_buffer_size <= i_cfg_buffer_size;
            end
            if (acc[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (acc[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (em_can) begin
                r_em_valid <= r_v[LAST];
            end
            if (out_load) begin
                r_out_valid <= r_em_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc[0]) begin
            r_bcd[0] <= '0;
            r_bin[0] <= in_mag;
            r_neg[0] <= i_value[VALUE_WIDTH-1];
            r_err[0] <= (r_buffer_size == '0);
        end
        for (int k = 1; k <= NUM_DD; k++) begin
            if (acc[k]) begin
                r_bcd[k] <= n_bcd[k];
                r_bin[k] <= n_bin[k];
                r_neg[k] <= r_neg[k-1];
                r_err[k] <= r_err[k-1];
            end
        end
        if (acc[LAST]) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                r_cdig[d] <= r_bcd[NUM_DD][d*4 +: 4];
            end
            r_ccnt <= n_ccnt;
            r_cneg <= r_neg[NUM_DD];
            r_cerr <= r_err[NUM_DD];
        end
        if (em_can) begin
            r_em_dig <= r_cdig;
            r_em_cnt <= r_ccnt;
            r_em_neg <= r_cneg;
            r_em_err <= r_cerr;
            r_em_pos <= '0;
        end else if (out_load && r_em_valid) begin
            r_em_pos <= r_em_pos + TOT_W'(1);
        end
        if (out_load) begin
            r_char  <= em_char;
            r_last  <= em_last;
            r_error <= r_em_err;
        end
    end

endmodule
